/* src/usbrh_pkg.sv */
// ----------------------------------------------------------------------------
// usbrh_pkg
// Types and constants shared by the root hub port status block and its checker.
// ----------------------------------------------------------------------------
package usbrh_pkg;

	// request modes
	localparam logic [2:0] MODE_GET_STATUS = 3'd0;
	localparam logic [2:0] MODE_SET_FEAT   = 3'd1;
	localparam logic [2:0] MODE_CLR_FEAT   = 3'd2;
	localparam logic [2:0] MODE_CONNECT    = 3'd3;
	localparam logic [2:0] MODE_DISCONNECT = 3'd4;
	localparam logic [2:0] MODE_TICK       = 3'd5;
	localparam logic [2:0] MODE_SET_ACTIVE = 3'd6;
	localparam logic [2:0] MODE_CLR_ACTIVE = 3'd7;

	// hub port feature selectors (bit numbers in the status word)
	localparam logic [4:0] F_CONNECTION   = 5'd0;
	localparam logic [4:0] F_ENABLE       = 5'd1;
	localparam logic [4:0] F_SUSPEND      = 5'd2;
	localparam logic [4:0] F_RESET        = 5'd4;
	localparam logic [4:0] F_POWER        = 5'd8;
	localparam logic [4:0] F_C_CONNECTION = 5'd16;
	localparam logic [4:0] F_C_SUSPEND    = 5'd18;
	localparam logic [4:0] F_C_RESET      = 5'd20;

	localparam logic [31:0] LOW_SPEED_FLAG  = 32'h0000_0200;
	localparam logic [31:0] HIGH_SPEED_FLAG = 32'h0000_0400;

	localparam logic [1:0] SPEED_LOW  = 2'd0;
	localparam logic [1:0] SPEED_HIGH = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_PORT_COUNT   = 2'd0;
	localparam logic [1:0] CFG_RESET_TICKS  = 2'd1;
	localparam logic [1:0] CFG_RESUME_TICKS = 2'd2;

	localparam logic [3:0] PORT_COUNT_RST   = 4'd8;
	localparam logic [9:0] RESET_TICKS_RST  = 10'd50;
	localparam logic [9:0] RESUME_TICKS_RST = 10'd20;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] port;
		logic [4:0] feature;
		logic [1:0] link_speed;
	} req_t;

	typedef struct packed {
		logic [15:0] status_low;
		logic [15:0] status_change;
		logic        no_device;
		logic        poll_request;
		logic        shutdown_link;
	} rsp_t;

	// one port entry of the state memory
	typedef struct packed {
		logic [31:0] status;
		logic [1:0]  speed;
		logic        active;
	} entry_t;

	function automatic logic [31:0] speed_flag(input logic [1:0] spd);
		logic [31:0] f;
		f = 32'd0;
		if (spd == SPEED_LOW) f = LOW_SPEED_FLAG;
		else if (spd == SPEED_HIGH) f = HIGH_SPEED_FLAG;
		return f;
	endfunction

endpackage

/* src/usb_root_hub_port_status_top.sv */
// ----------------------------------------------------------------------------
// usb_root_hub_port_status_top
// Root hub port status words with set/clear feature, connect and timer logic.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req): one request per transfer:
//   get status, set/clear feature, connect, disconnect, ms tick, set/clear
//   active. rsp channel (rsp_valid / rsp_stall / rsp): exactly one response
//   transfer per request, in order.
//   Per-port state (status word, speed, active) sits in a synchronous RAM
//   with a registered read. A request is accepted and its entry read into
//   stage 1; once the output register is free the entry is modified,
//   written back and the response loaded into the output register. A new
//   request is taken only after the previous one is written back; only
//   one request is in flight, so reads never see a stale entry.
//   When rsp is stalled the finished response holds in the output register;
//   one more request can be taken and waits in stage 1 until it drains.
//   Reset: per-entry valid flops clear at once (an invalid entry reads as
//   zero), the timer is expired, config returns to 8 ports / 50 / 20 ticks.
//   Config writes (cfg_we/cfg_index/cfg_data) are taken any cycle, no wait.
// ----------------------------------------------------------------------------
module usb_root_hub_port_status_top
	import usbrh_pkg::*;
#(
	parameter int NUM_PORTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam logic [4:0] NPORTS5 = 5'(NUM_PORTS);

	// configuration
	logic [3:0]  port_count_q;
	logic [9:0]  reset_ticks_q;
	logic [9:0]  resume_ticks_q;

	// hub-wide timer state
	logic [10:0] timer_q;
	logic        resume_pending_q;

	// port state RAM and per-entry valid bits
	entry_t          mem [NUM_PORTS];
	logic [NUM_PORTS-1:0] ent_vld_q;

	// stage 1: request waiting on the RAM read
	logic    valid_s1;
	req_t    req_s1;
	entry_t  rd_s1;
	logic    rd_vld_s1;

	// output register
	logic    rsp_valid_q;
	rsp_t    rsp_q;

	logic    accept;
	logic    done;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	assign req_stall = valid_s1;
	assign accept    = req_valid && !valid_s1;
	assign done      = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign rd_addr   = req.port[AW-1:0];
	assign wr_addr   = req_s1.port[AW-1:0];

	// ---------------- modify step ----------------
	logic [4:0]  count5;
	logic        in_range;
	entry_t      ent;
	entry_t      ent_n;
	logic [10:0] timer_n;
	logic        rp_n;
	rsp_t        rsp_n;
	logic        wr_en;
	logic [31:0] fbit;
	logic        expired;

	always_comb begin
		count5   = ({1'b0, port_count_q} < NPORTS5) ? {1'b0, port_count_q} : NPORTS5;
		in_range = ({1'b0, req_s1.port} < count5);
		ent      = rd_vld_s1 ? rd_s1 : '0;
		ent_n    = ent;
		timer_n  = timer_q;
		rp_n     = resume_pending_q;
		rsp_n    = '0;
		wr_en    = 1'b0;
		fbit     = 32'd1 << req_s1.feature;
		expired  = (timer_q == 11'd0);

		if (req_s1.mode == MODE_TICK) begin
			if (!expired) timer_n = timer_q - 11'd1;
		end else if (!in_range) begin
			rsp_n.no_device = 1'b1;
		end else begin
			wr_en = 1'b1;
			case (req_s1.mode)
				MODE_GET_STATUS: begin
					if (resume_pending_q && expired) begin
						ent_n.status[F_C_SUSPEND] = 1'b1;
						ent_n.status[F_SUSPEND]   = 1'b0;
						rp_n = 1'b0;
					end
					if (ent_n.status[F_RESET] && expired) begin
						ent_n.status[F_C_RESET] = 1'b1;
						ent_n.status[F_RESET]   = 1'b0;
						if (ent.active) ent_n.status[F_ENABLE] = 1'b1;
					end
					rsp_n.status_low    = ent_n.status[15:0];
					rsp_n.status_change = ent_n.status[31:16];
				end
				MODE_SET_FEAT: begin
					if (req_s1.feature != F_SUSPEND) begin
						if (req_s1.feature == F_RESET) begin
							ent_n.status[F_ENABLE] = 1'b0;
							timer_n = {1'b0, reset_ticks_q} + 11'd1;
						end
						ent_n.status = ent_n.status | fbit;
					end
				end
				MODE_CLR_FEAT: begin
					if (req_s1.feature == F_SUSPEND) begin
						if (ent.status[F_SUSPEND]) begin
							rp_n    = 1'b1;
							timer_n = {1'b0, resume_ticks_q} + 11'd1;
						end
					end else if (req_s1.feature == F_POWER) begin
						ent_n.status = 32'd0;
						rp_n = 1'b0;
					end else if (req_s1.feature == F_C_RESET) begin
						ent_n.status = (ent.status | speed_flag(ent.speed)) & ~fbit;
					end else begin
						rsp_n.shutdown_link = (req_s1.feature == F_ENABLE) && ent.active;
						ent_n.status = ent.status & ~fbit;
					end
				end
				MODE_CONNECT: begin
					ent_n.status[F_CONNECTION]   = 1'b1;
					ent_n.status[F_C_CONNECTION] = 1'b1;
					ent_n.status = ent_n.status | speed_flag(req_s1.link_speed);
					ent_n.speed  = req_s1.link_speed;
					rsp_n.poll_request = 1'b1;
				end
				MODE_DISCONNECT: begin
					ent_n.status[F_CONNECTION]   = 1'b0;
					ent_n.status[F_C_CONNECTION] = 1'b1;
					rsp_n.poll_request = 1'b1;
				end
				MODE_SET_ACTIVE: ent_n.active = 1'b1;
				MODE_CLR_ACTIVE: ent_n.active = 1'b0;
				default: wr_en = 1'b0;
			endcase
		end
	end

	// ---------------- RAM: registered read, write-back on completion ----------------
	always_ff @(posedge clk) begin
		if (accept) rd_s1 <= mem[rd_addr];
		if (done && wr_en) mem[wr_addr] <= ent_n;
	end

	// stage 1 payload, output payload (no reset needed)
	always_ff @(posedge clk) begin
		if (accept) req_s1 <= req;
		if (done) rsp_q <= rsp_n;
	end

	// control and hub-wide state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			rd_vld_s1        <= 1'b0;
			rsp_valid_q      <= 1'b0;
			ent_vld_q        <= '0;
			timer_q          <= 11'd0;
			resume_pending_q <= 1'b0;
			port_count_q     <= PORT_COUNT_RST;
			reset_ticks_q    <= RESET_TICKS_RST;
			resume_ticks_q   <= RESUME_TICKS_RST;
		end else begin
			if (accept) begin
				valid_s1  <= 1'b1;
				rd_vld_s1 <= ent_vld_q[rd_addr];
			end else if (done) begin
				valid_s1  <= 1'b0;
			end

			if (done) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;

			if (done) begin
				timer_q          <= timer_n;
				resume_pending_q <= rp_n;
				if (wr_en) ent_vld_q[wr_addr] <= 1'b1;
			end

			if (cfg_we) begin
				case (cfg_index)
					CFG_PORT_COUNT:   port_count_q   <= cfg_data[3:0];
					CFG_RESET_TICKS:  reset_ticks_q  <= cfg_data;
					CFG_RESUME_TICKS: resume_ticks_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* src/usbrh_checker.sv */
// ----------------------------------------------------------------------------
// usbrh_checker
// Port-level assertions for the root hub port status block, bound to the top.
// ----------------------------------------------------------------------------
module usbrh_checker
	import usbrh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// held response stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in flight: a transfer in closes the request side next cycle
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in flight");

	// a rejected port carries no status and no side flags
	a_nodev_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.no_device |->
			rsp.status_low == 16'd0 && rsp.status_change == 16'd0 &&
			!rsp.poll_request && !rsp.shutdown_link)
		else $error("no_device response with other fields set");

	// poll comes from connect/disconnect, shutdown from clear feature
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.poll_request && rsp.shutdown_link))
		else $error("poll and shutdown in one response");

endmodule

bind usb_root_hub_port_status_top usbrh_checker u_usbrh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
